[design/prre_pkg.sv]
// ----------------------------------------------------------------------------
// prre_pkg: shared types and constants of the rank engine
// Request and result structs, command codes and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none
package prre_pkg;

    localparam int MaxVertices  = 1024;
    localparam int DegreeBits   = 20;
    localparam int VertexBits   = 10;
    localparam int RankBits     = 32;
    localparam int DampingBits  = 16;
    localparam int CountBits    = 11;
    localparam int DampingReset = 55705;
    localparam int CountReset   = 1024;

    // Command codes of a request.
    localparam logic [1:0] CmdLoad   = 2'd0;
    localparam logic [1:0] CmdEdge   = 2'd1;
    localparam logic [1:0] CmdFinish = 2'd2;
    localparam logic [1:0] CmdRead   = 2'd3;

    // Configuration register indexes.
    localparam logic [0:0] CfgDamping = 1'b0;
    localparam logic [0:0] CfgCount   = 1'b1;

    typedef struct packed {
        logic [1:0]            command;
        logic [VertexBits-1:0] source_vertex;
        logic [VertexBits-1:0] target_vertex;
        logic [19:0]           out_degree;
    } t_request;

    typedef struct packed {
        logic [RankBits-1:0] rank_value;
        logic                iteration_done;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the request
        logic rd_src;    // read degree and both banks at the source
        logic rd_walk;   // read next bank at the walk address
        logic div_start; // start the divider
        logic wr_load;   // write a load
        logic rd_dst;    // read next bank at the target
        logic wr_edge;   // write the saturated sum at the target
        logic mul_walk;  // register the damping product
        logic wr_walk;   // write both banks at the walk address
        logic walk_inc;  // step the walk address
        logic swap;      // swap banks
        logic emit;      // present the result
        logic tele_start;// start the teleport division
        logic onen_start;// start the 1/n division
    } t_ctrl;

    typedef struct packed {
        logic div_done;
        logic walk_last;
        logic src_ok;
        logic deg_zero;
    } t_status;

endpackage
`default_nettype wire

[design/prre_divider.sv]
// ----------------------------------------------------------------------------
// prre_divider: restoring divider
// Produces a 48-bit by 32-bit unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module prre_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [47:0]      o_quot
);
    logic [47:0] r_quot, n_quot;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [32:0] w_shift;

    // One quotient bit per cycle.
    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_shift = {r_rem[31:0], r_quot[47]};
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_den}) begin
                n_rem  = w_shift - {1'b0, r_den};
                n_quot = {r_quot[46:0], 1'b1};
            end else begin
                n_rem  = w_shift;
                n_quot = {r_quot[46:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd47) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

[design/prre_datapath.sv]
// ----------------------------------------------------------------------------
// prre_datapath: rank banks, degree table and arithmetic
// Holds the memories, the divider, the damping multiplier and saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module prre_datapath #(
    parameter int MAX_VERTICES = prre_pkg::MaxVertices,
    parameter int DEGREE_BITS  = prre_pkg::DegreeBits
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire prre_pkg::t_request       i_req,
    input  wire logic [15:0]              i_damping,
    input  wire logic [10:0]              i_count,
    input  wire prre_pkg::t_ctrl          i_ctrl,
    output prre_pkg::t_status             o_status,
    output prre_pkg::t_result             o_result
);
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic [31:0]            r_bank0 [MAX_VERTICES];
    logic [31:0]            r_bank1 [MAX_VERTICES];
    logic [DEGREE_BITS-1:0] r_deg   [MAX_VERTICES];

    prre_pkg::t_request r_req;
    logic               r_swap;
    logic [AW-1:0]      r_addr;
    logic [31:0]        r_rd0, r_rd1;
    logic [DEGREE_BITS-1:0] r_rdeg;
    logic [31:0]        r_tele;
    logic [47:0]        r_prod;
    logic [31:0]        r_rank;
    logic               r_emit, r_done_bit;
    logic [31:0]        r_quot_hold;

    logic        w_div_done;
    logic [47:0] w_quot, w_num;
    logic [31:0] w_den, w_cur, w_nxt, w_wr_val, w_walk_val;
    logic [10:0] w_n;
    logic [32:0] w_sum, w_tsum;
    logic        w_src_ok, w_dst_ok;
    logic [AW-1:0] w_src, w_dst, w_rdaddr;

    assign w_n = (i_count == 11'd0) ? 11'd1 : i_count;
    // Index range checks, for a vertex field wider than the array.
    assign w_src_ok = 32'(r_req.source_vertex) < 32'(MAX_VERTICES);
    assign w_dst_ok = 32'(r_req.target_vertex) < 32'(MAX_VERTICES);
    assign w_src    = AW'(r_req.source_vertex);
    assign w_dst    = AW'(r_req.target_vertex);

    // Divider operands: teleport, 1/n or the edge share.
    always_comb begin
        if (i_ctrl.tele_start) begin
            w_num = {(17'h10000 - {1'b0, i_damping}), 31'd0};
            w_den = {5'd0, w_n, 16'd0};
        end else if (i_ctrl.onen_start) begin
            w_num = 48'h8000_0000;
            w_den = 32'(w_n);
        end else begin
            w_num = 48'(w_cur);
            w_den = 32'(r_rdeg);
        end
    end

    prre_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.div_start | i_ctrl.tele_start | i_ctrl.onen_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_cur = r_swap ? r_rd1 : r_rd0;
    assign w_nxt = r_swap ? r_rd0 : r_rd1;

    // Saturating sums for edge and walk updates.
    assign w_sum      = {1'b0, w_nxt} + {1'b0, r_quot_hold};
    assign w_wr_val   = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
    assign w_tsum     = {1'b0, r_prod[47:16]} + {1'b0, r_tele};
    assign w_walk_val = w_tsum[32] ? 32'hFFFF_FFFF : w_tsum[31:0];
    assign w_rdaddr   = i_ctrl.rd_walk ? r_addr : (i_ctrl.rd_dst ? w_dst : w_src);

    // Request capture, bank select, walk address and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap <= 1'b0;
            r_addr <= '0;
            r_emit <= 1'b0;
        end else begin
            r_emit <= i_ctrl.emit;
            if (i_ctrl.swap) begin
                r_swap <= ~r_swap;
            end
            if (i_ctrl.capture) begin
                r_addr <= '0;
            end else if (i_ctrl.walk_inc) begin
                r_addr <= r_addr + AW'(1);
            end
        end
        if (i_ctrl.capture) begin
            r_req <= i_req;
        end
        if (w_div_done) begin
            if (r_req.command == prre_pkg::CmdFinish) begin
                r_tele <= w_quot[31:0];
            end else begin
                r_quot_hold <= w_quot[31:0];
            end
        end
        if (i_ctrl.mul_walk) begin
            r_prod <= 48'(i_damping) * 48'(w_nxt);
        end
        if (i_ctrl.emit) begin
            r_rank     <= (r_req.command == prre_pkg::CmdRead && w_src_ok) ? w_cur : 32'd0;
            r_done_bit <= (r_req.command == prre_pkg::CmdFinish);
        end
    end

    // Memories: one read address and one write per bank per cycle.
    // A load writes 1/n straight from the divider while its done flag is up.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_src || i_ctrl.rd_walk || i_ctrl.rd_dst) begin
            r_rd0 <= r_bank0[w_rdaddr];
            r_rd1 <= r_bank1[w_rdaddr];
        end
        if (i_ctrl.rd_src) begin
            r_rdeg <= r_deg[w_src];
        end
        if (i_ctrl.wr_load) begin
            r_deg[w_src] <= DEGREE_BITS'(r_req.out_degree);
            r_bank0[w_src] <= r_swap ? 32'd0 : w_quot[31:0];
            r_bank1[w_src] <= r_swap ? w_quot[31:0] : 32'd0;
        end else if (i_ctrl.wr_edge) begin
            if (r_swap) begin
                r_bank0[w_dst] <= w_wr_val;
            end else begin
                r_bank1[w_dst] <= w_wr_val;
            end
        end else if (i_ctrl.wr_walk) begin
            r_bank0[r_addr] <= r_swap ? w_walk_val : 32'd0;
            r_bank1[r_addr] <= r_swap ? 32'd0 : w_walk_val;
        end
    end

    assign o_status.div_done  = w_div_done;
    assign o_status.walk_last = (32'(r_addr) == 32'(MAX_VERTICES - 1));
    assign o_status.src_ok    = w_src_ok && (r_req.command != prre_pkg::CmdEdge || w_dst_ok);
    assign o_status.deg_zero  = (r_rdeg == '0);
    assign o_result.rank_value     = r_emit ? r_rank : 32'd0;
    assign o_result.iteration_done = r_emit & r_done_bit;
endmodule
`default_nettype wire

[design/prre_controller.sv]
// ----------------------------------------------------------------------------
// prre_controller: command sequencer of the rank engine
// Steps each request through reads, divisions, writes and the finish walk.
// ----------------------------------------------------------------------------
`default_nettype none
module prre_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         i_command,
    input  wire prre_pkg::t_status  i_status,
    output logic                    busy,
    output prre_pkg::t_ctrl         o_ctrl
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_READ, S_DIV, S_DST, S_WRITE, S_LOAD_DIV,
        S_TELE_DIV, S_WALK_RD, S_WALK_MUL, S_WALK_WR, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    prre_pkg::t_ctrl n_ctrl;
    logic [1:0] r_cmd, n_cmd;

    // Next-state and command decode.
    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_cmd   = r_cmd;
        n_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_ctrl.capture = 1'b1;
                    n_cmd   = i_command;
                    n_busy  = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                case (r_cmd)
                    prre_pkg::CmdFinish: begin
                        n_ctrl.tele_start = 1'b1;
                        n_state = S_TELE_DIV;
                    end
                    prre_pkg::CmdLoad: begin
                        if (i_status.src_ok) begin
                            n_ctrl.onen_start = 1'b1;
                            n_state = S_LOAD_DIV;
                        end else begin
                            n_ctrl.emit = 1'b1;
                            n_state = S_EMIT;
                        end
                    end
                    default: begin
                        if (i_status.src_ok) begin
                            n_ctrl.rd_src = 1'b1;
                            n_state = S_READ;
                        end else begin
                            n_ctrl.emit = 1'b1;
                            n_state = S_EMIT;
                        end
                    end
                endcase
            end
            S_READ: begin
                if (r_cmd == prre_pkg::CmdRead || i_status.deg_zero) begin
                    n_ctrl.emit = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_ctrl.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_ctrl.rd_dst = 1'b1;
                    n_state = S_DST;
                end
            end
            S_DST: begin
                n_ctrl.wr_edge = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                n_ctrl.emit = 1'b1;
                n_state = S_EMIT;
            end
            S_LOAD_DIV: begin
                if (i_status.div_done) begin
                    n_ctrl.wr_load = 1'b1;
                    n_state = S_WRITE;
                end
            end
            S_TELE_DIV: begin
                if (i_status.div_done) begin
                    n_ctrl.rd_walk = 1'b1;
                    n_state = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                n_ctrl.mul_walk = 1'b1;
                n_state = S_WALK_MUL;
            end
            S_WALK_MUL: begin
                // Write this slot; the last slot ends the walk, others advance.
                n_ctrl.wr_walk = 1'b1;
                if (i_status.walk_last) begin
                    n_ctrl.swap = 1'b1;
                    n_ctrl.emit = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_ctrl.walk_inc = 1'b1;
                    n_state = S_WALK_WR;
                end
            end
            S_WALK_WR: begin
                // The address has advanced; read the next slot.
                n_ctrl.rd_walk = 1'b1;
                n_state = S_WALK_RD;
            end
            S_EMIT: begin
                n_busy  = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    // State, busy flag and captured command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_cmd   <= prre_pkg::CmdLoad;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_cmd   <= n_cmd;
        end
    end

    // Commands act at the edge that ends the cycle they are decoded in.
    assign o_ctrl = n_ctrl;
    assign busy   = r_busy;
endmodule
`default_nettype wire

[design/pagerank_rank_engine_top.sv]
// ----------------------------------------------------------------------------
// pagerank_rank_engine_top: PageRank rank engine
// Load, edge, finish and read requests over two rank banks in block RAM.
// ----------------------------------------------------------------------------
// Each request gives exactly one result strobe on o_result_valid, which the
// receiver cannot stall. Busy stays high until that strobe. Load and edge
// requests wait on the bit-serial 48-step divider, a finish on the divider
// and then on a walk over all MAX_VERTICES vertex slots; the next request
// can be accepted in the cycle after the strobe. Memory contents are
// undefined until loaded.
`default_nettype none
module pagerank_rank_engine_top #(
    parameter int MAX_VERTICES = prre_pkg::MaxVertices,
    parameter int DEGREE_BITS  = prre_pkg::DegreeBits
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire prre_pkg::t_request i_request,
    output logic                    o_result_valid,
    output prre_pkg::t_result       o_result,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);
    logic [15:0] r_damping;
    logic [10:0] r_count;
    logic        r_valid;
    prre_pkg::t_ctrl   w_ctrl;
    prre_pkg::t_status w_status;
    prre_pkg::t_result w_result;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damping <= 16'(prre_pkg::DampingReset);
            r_count   <= 11'(prre_pkg::CountReset);
            r_valid   <= 1'b0;
        end else begin
            r_valid <= w_ctrl.emit;
            if (i_cfg_valid) begin
                if (i_cfg_index == prre_pkg::CfgDamping) begin
                    r_damping <= i_cfg_data;
                end else begin
                    r_count <= i_cfg_data[10:0];
                end
            end
        end
    end

    prre_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_request.command),
        .i_status  (w_status),
        .busy      (busy),
        .o_ctrl    (w_ctrl)
    );

    prre_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .DEGREE_BITS  (DEGREE_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_request),
        .i_damping (r_damping),
        .i_count   (r_count),
        .i_ctrl    (w_ctrl),
        .o_status  (w_status),
        .o_result  (w_result)
    );

    assign o_result_valid = r_valid;
    assign o_result       = w_result;
endmodule
`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: rank engine request and result check
// Loads every vertex, runs directed corner requests, then random mixes of
// load, edge, read and finish requests under several damping and count
// settings, and compares every result strobe with a rank predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Predicts rank results and holds the ones still owed by the engine.
class rank_scoreboard;
    bit [31:0] bank [2][prre_pkg::MaxVertices];
    bit [19:0] degree [prre_pkg::MaxVertices];
    bit bank_sel;
    bit [15:0] damping;
    bit [10:0] count;
    prre_pkg::t_result owed[$];
    int errors;

    function new();
        bank_sel = 1'b0;
        damping = prre_pkg::DampingReset;
        count = prre_pkg::CountReset;
        errors = 0;
    endfunction

    function void write_register(bit [0:0] index, bit [15:0] data);
        if (index == prre_pkg::CfgDamping)
            damping = data;
        else
            count = data[10:0];
    endfunction

    static function bit [31:0] saturate(bit [63:0] sum);
        return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Applies an accepted request and queues its expected result.
    function void note_request(prre_pkg::t_request req);
        bit [63:0] n;
        bit [63:0] teleport;
        bit [63:0] damped;
        bit cur;
        prre_pkg::t_result res;
        cur = bank_sel;
        n = (count == 0) ? 64'd1 : 64'(count);
        res = '0;
        case (req.command)
            prre_pkg::CmdLoad: begin
                degree[req.source_vertex] = req.out_degree;
                bank[cur][req.source_vertex] = 32'((64'd1 << 31) / n);
                bank[!cur][req.source_vertex] = '0;
            end
            prre_pkg::CmdEdge: begin
                if (degree[req.source_vertex] != 0)
                    bank[!cur][req.target_vertex] = saturate(
                        64'(bank[!cur][req.target_vertex]) +
                        64'(bank[cur][req.source_vertex]) /
                        64'(degree[req.source_vertex]));
            end
            prre_pkg::CmdFinish: begin
                teleport = (64'(17'd65536 - 17'(damping)) << 31) / (n << 16);
                for (int v = 0; v < prre_pkg::MaxVertices; v++) begin
                    damped = (64'(damping) * 64'(bank[!cur][v])) >> 16;
                    bank[!cur][v] = saturate(damped + teleport);
                    bank[cur][v] = '0;
                end
                bank_sel = !cur;
                res.iteration_done = 1'b1;
            end
            default: begin
                res.rank_value = bank[cur][req.source_vertex];
            end
        endcase
        owed.push_back(res);
    endfunction

    // Compares one result strobe with the oldest expectation.
    function void check_result(prre_pkg::t_result got);
        prre_pkg::t_result want;
        if (owed.size() == 0) begin
            $error("unexpected result rank_value=%0h iteration_done=%0b",
                   got.rank_value, got.iteration_done);
            errors++;
            return;
        end
        want = owed.pop_front();
        if (got.rank_value !== want.rank_value) begin
            $error("rank_value expected %0h actual %0h", want.rank_value, got.rank_value);
            errors++;
        end
        if (got.iteration_done !== want.iteration_done) begin
            $error("iteration_done expected %0b actual %0b",
                   want.iteration_done, got.iteration_done);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int StallLimit = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    prre_pkg::t_request i_request = '0;
    logic o_result_valid;
    prre_pkg::t_result o_result;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [0:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    rank_scoreboard ranks = new();
    bit idling = 1'b1;
    int quiet_cycles = 0;
    bit moved;

    pagerank_rank_engine_top DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_request(i_request),
        .o_result_valid(o_result_valid),
        .o_result(o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result strobes are checked at the edge that ends them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            ranks.check_result(o_result);
        end
    end

    // Watchdog on cycles with no request, result or register write accepted.
    always @(posedge i_clk) begin
        moved = (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready);
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sends one request; called and returning at a falling edge.
    task automatic send_request(prre_pkg::t_request req);
        bit taken;
        if (idling && $urandom_range(0, 5) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        start = 1'b1;
        i_request = req;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
            if (taken) ranks.note_request(req);
            @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start = 1'b0;
        while (ranks.owed.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_register(bit [0:0] index, bit [15:0] data);
        bit taken;
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data = data;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_cfg_ready;
            if (taken) ranks.write_register(index, data);
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
    endtask

    function automatic prre_pkg::t_request request_of(logic [1:0] cmd, int src, int dst,
                                                      int deg);
        prre_pkg::t_request req;
        req.command = cmd;
        req.source_vertex = src[9:0];
        req.target_vertex = dst[9:0];
        req.out_degree = deg[19:0];
        return req;
    endfunction

    // Random request: mostly edges and reads, now and then a finish.
    function automatic prre_pkg::t_request random_request();
        int pick;
        int deg;
        pick = $urandom_range(0, 99);
        deg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                          : $urandom_range(0, 6);
        if (pick < 10)
            return request_of(prre_pkg::CmdLoad, $urandom_range(0, 1023),
                              $urandom_range(0, 1023), deg);
        if (pick < 66)
            return request_of(prre_pkg::CmdEdge, $urandom_range(0, 1023),
                              $urandom_range(0, 1023), deg);
        if (pick < 98)
            return request_of(prre_pkg::CmdRead, $urandom_range(0, 1023),
                              $urandom_range(0, 1023), deg);
        return request_of(prre_pkg::CmdFinish, $urandom_range(0, 1023),
                          $urandom_range(0, 1023), deg);
    endfunction

    initial begin
        bit [15:0] damp_set [6];
        bit [15:0] count_set [6];
        damp_set = '{16'd0, 16'd65535, 16'd55705, 16'd0, 16'd0, 16'd32768};
        count_set = '{16'd0, 16'd1, 16'd2047, 16'd1024, 16'd0, 16'd3};
        damp_set[3] = $urandom_range(0, 65535);
        count_set[4] = $urandom_range(0, 65535);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Small n and full damping drive sums into saturation.
        write_register(prre_pkg::CfgDamping, 16'd65535);
        write_register(prre_pkg::CfgCount, 16'd1);

        // Every vertex is loaded first so no store entry is read unwritten.
        for (int v = 0; v < prre_pkg::MaxVertices; v++) begin
            int deg;
            case (v)
                0: deg = 0;
                1: deg = 1;
                2: deg = 20'hFFFFF;
                default: deg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                           : $urandom_range(0, 5);
            endcase
            send_request(request_of(prre_pkg::CmdLoad, v, $urandom_range(0, 1023), deg));
        end

        // Directed corners: saturation, zero degree, widest degree, last vertex.
        send_request(request_of(prre_pkg::CmdEdge, 1, 5, 0));
        send_request(request_of(prre_pkg::CmdEdge, 1, 5, 20'hFFFFF));
        send_request(request_of(prre_pkg::CmdEdge, 1, 5, 0));
        send_request(request_of(prre_pkg::CmdEdge, 0, 6, 0));
        send_request(request_of(prre_pkg::CmdEdge, 2, 7, 0));
        send_request(request_of(prre_pkg::CmdEdge, 1023, 1023, 0));
        send_request(request_of(prre_pkg::CmdRead, 1, 1023, 20'hFFFFF));
        send_request(request_of(prre_pkg::CmdRead, 1023, 0, 0));
        send_request(request_of(prre_pkg::CmdRead, 0, 0, 0));
        send_request(request_of(prre_pkg::CmdFinish, 0, 0, 0));
        send_request(request_of(prre_pkg::CmdRead, 5, 0, 0));
        send_request(request_of(prre_pkg::CmdRead, 7, 0, 0));
        send_request(request_of(prre_pkg::CmdRead, 6, 0, 0));
        send_request(request_of(prre_pkg::CmdEdge, 5, 9, 0));
        send_request(request_of(prre_pkg::CmdLoad, 1023, 0, 20'hFFFFF));
        send_request(request_of(prre_pkg::CmdRead, 1023, 0, 0));
        send_request(request_of(prre_pkg::CmdFinish, 1023, 1023, 20'hFFFFF));
        send_request(request_of(prre_pkg::CmdRead, 9, 0, 0));

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            write_register(prre_pkg::CfgDamping, damp_set[phase]);
            write_register(prre_pkg::CfgCount, count_set[phase]);
            idling = (phase < 5);
            for (int k = 0; k < 43; k++) begin
                send_request(random_request());
            end
        end

        drain();
        if (ranks.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
